>>> src/vbb_pkg.sv
// ----------------------------------------------------------------------------
// vbb_pkg
// Shared widths, register indexes and types of the vertical box blur.
// ----------------------------------------------------------------------------
package vbb_pkg;

  // channel and pixel widths
  localparam int CH_W       = 8;
  localparam int CHANNELS   = 3;
  localparam int PIX_W      = CH_W * CHANNELS;

  // image geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // line stores: one slot per held row
  localparam int SLOTS      = 4;
  localparam int SLOT_W     = $clog2(SLOTS);

  // results per word: up to three on the last row
  localparam int CNT_W      = 2;

  // configuration registers
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd480;

  // stream word widths
  localparam int IN_DATA_W  = PIX_W;
  localparam int OUT_DATA_W = 48;

  typedef logic [PIX_W-1:0] pix_t;

  // per-word control decided at acceptance
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [CNT_W-1:0] cnt;     // number of results this word causes
    logic [CNT_W-1:0] top;     // rows between the first result and the current row
    logic             avg_ok;  // the oldest emitted row gets the average
  } vbb_item_t;

endpackage

>>> src/vbb_ctrl.sv
// ----------------------------------------------------------------------------
// vbb_ctrl
// Size registers, raster counters and per-word control for the box blur.
// ----------------------------------------------------------------------------
module vbb_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [vbb_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [vbb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                         accept,
  output vbb_pkg::vbb_item_t           item
);
  import vbb_pkg::*;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [COL_W-1:0]        column_counter;
  logic [ROW_W-1:0]        row_counter;

  logic [WIDTH_REG_W-1:0]  w_clamp;
  logic [HEIGHT_REG_W-1:0] h_clamp;
  logic                    last_col;
  logic                    last_row;
  logic [COL_W-1:0]        column_counter_next;
  logic [ROW_W-1:0]        row_counter_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero size counts as one, oversize is cut to the maximum
  always_comb begin
    if (image_width == '0) begin
      w_clamp = WIDTH_REG_W'(1);
    end else if (image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_clamp = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_clamp = image_width;
    end
    if (image_height == '0) begin
      h_clamp = HEIGHT_REG_W'(1);
    end else if (image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_clamp = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      h_clamp = image_height;
    end
  end

  assign last_col = (WIDTH_REG_W'(column_counter) + WIDTH_REG_W'(1)) >= w_clamp;
  assign last_row = (HEIGHT_REG_W'(row_counter) + HEIGHT_REG_W'(1)) >= h_clamp;

  // control for the word at the current position
  always_comb begin
    item.col = column_counter;
    item.row = row_counter;
    if (last_row) begin
      // flush from max(0, row-2) down to the current row
      item.cnt = (row_counter >= ROW_W'(2)) ? CNT_W'(3) :
                 CNT_W'(row_counter[0]) + CNT_W'(1);
      item.top = (row_counter >= ROW_W'(2)) ? CNT_W'(2) : CNT_W'(row_counter[0]);
    end else begin
      item.cnt = (row_counter >= ROW_W'(2)) ? CNT_W'(1) : CNT_W'(0);
      item.top = CNT_W'(2);
    end
    item.avg_ok = (row_counter >= ROW_W'(4)) &&
                  (HEIGHT_REG_W'(row_counter) <= (h_clamp - HEIGHT_REG_W'(1)));
  end

  // raster position advance
  always_comb begin
    if (last_col) begin
      column_counter_next = '0;
      row_counter_next    = last_row ? '0 : row_counter + ROW_W'(1);
    end else begin
      column_counter_next = column_counter + COL_W'(1);
      row_counter_next    = row_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
    end else if (accept) begin
      column_counter <= column_counter_next;
      row_counter    <= row_counter_next;
    end
  end

endmodule

>>> src/vbb_line_store.sv
// ----------------------------------------------------------------------------
// vbb_line_store
// Four row memories; all are read at the column, one slot is written.
// ----------------------------------------------------------------------------
module vbb_line_store (
  input  logic                               clk,
  input  logic                               accept,
  input  logic [vbb_pkg::COL_W-1:0]          col,
  input  logic [vbb_pkg::SLOT_W-1:0]         wr_slot,
  input  vbb_pkg::pix_t                      wr_pix,
  output logic [vbb_pkg::SLOTS-1:0][vbb_pkg::PIX_W-1:0] rd_pix
);
  import vbb_pkg::*;

  for (genvar g = 0; g < SLOTS; g++) begin : g_slot
    logic [PIX_W-1:0] mem [MAX_WIDTH];

    // read old contents, then write the new row in its slot
    always_ff @(posedge clk) begin
      if (accept) begin
        rd_pix[g] <= mem[col];
        if (wr_slot == SLOT_W'(g)) begin
          mem[col] <= wr_pix;
        end
      end
    end
  end

endmodule

>>> src/vbb_emit.sv
// ----------------------------------------------------------------------------
// vbb_emit
// Holding stage, 5-row average and output register of the box blur.
// ----------------------------------------------------------------------------
module vbb_emit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  vbb_pkg::vbb_item_t                 item,
  input  vbb_pkg::pix_t                      cur_pix,
  input  logic [vbb_pkg::SLOTS-1:0][vbb_pkg::PIX_W-1:0] rd_pix,
  output logic                               out_valid,
  input  logic                               out_ready,
  output vbb_pkg::pix_t                      out_pix,
  output logic [vbb_pkg::COL_W-1:0]          out_col,
  output logic [vbb_pkg::ROW_W-1:0]          out_row,
  output logic                               out_last
);
  import vbb_pkg::*;

  localparam int SUM_W   = CH_W + 3;
  localparam int RECIP_S = 13;
  // floor(s/5) == (s * 1639) >> 13 for every sum of five channels
  localparam logic [SUM_W-1:0] RECIP5 = SUM_W'(1639);

  logic              accept;
  logic              s1_valid;
  vbb_item_t         s1_item;
  pix_t              s1_pix;
  logic [CNT_W-1:0]  s1_k;

  logic [CNT_W-1:0]  rows_up;
  logic              res_last;
  logic              load;
  logic              s1_done;
  pix_t              rows [SLOTS];
  pix_t              avg_pix;
  pix_t              res_pix;

  assign accept = in_valid && in_ready;

  // rows[i] holds row y-4+i of this column
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      rows[i] = rd_pix[SLOT_W'(s1_item.row[SLOT_W-1:0] + SLOT_W'(i))];
    end
  end

  // per-channel sum of five rows and division by five
  always_comb begin
    logic [SUM_W-1:0]         sum;
    logic [2*SUM_W-1:0]       prod;
    for (int c = 0; c < CHANNELS; c++) begin
      sum = SUM_W'(rows[0][c*CH_W +: CH_W]) + SUM_W'(rows[1][c*CH_W +: CH_W]) +
            SUM_W'(rows[2][c*CH_W +: CH_W]) + SUM_W'(rows[3][c*CH_W +: CH_W]) +
            SUM_W'(s1_pix[c*CH_W +: CH_W]);
      prod = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP5);
      avg_pix[c*CH_W +: CH_W] = prod[RECIP_S +: CH_W];
    end
  end

  // distance of this result's row above the current row
  assign rows_up  = s1_item.top - s1_k;
  assign res_last = (s1_k == s1_item.cnt - CNT_W'(1));

  always_comb begin
    case (rows_up)
      2'd2:    res_pix = s1_item.avg_ok ? avg_pix : rows[2];
      2'd1:    res_pix = rows[3];
      default: res_pix = s1_pix;
    endcase
  end

  // stage handshake: one result per cycle into a free output register
  assign load     = s1_valid && (s1_item.cnt != '0) && (!out_valid || out_ready);
  assign s1_done  = s1_valid && ((s1_item.cnt == '0) || (load && res_last));
  assign in_ready = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_k     <= '0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      s1_k     <= '0;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_k <= s1_k + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
      s1_pix  <= cur_pix;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pix  <= res_pix;
      out_col  <= s1_item.col;
      out_row  <= s1_item.row - ROW_W'(rows_up);
      out_last <= res_last;
    end
  end

  // result index stays within the word's result count
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid && (s1_item.cnt != '0) |-> s1_k <= s1_item.cnt - CNT_W'(1))
    else $error("result index past result count");

  // a new word only enters an empty or finishing stage
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    accept |-> !s1_valid || s1_done)
    else $error("word accepted over a busy stage");

  // a word keeps its place until its final result is loaded
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    load && !res_last |=> s1_valid && $stable(s1_item))
    else $error("word left before its final result");

  // words without results never reach the output
  a_no_empty_load: assert property (@(posedge clk) disable iff (rst)
    load |-> s1_item.cnt != '0)
    else $error("result loaded for a word without results");

endmodule

>>> src/vertical_box_blur_rgb.sv
// ----------------------------------------------------------------------------
// vertical_box_blur_rgb
// Vertical 5-tap box filter on an RGB raster stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order and returns the pixel two rows
// above in the same column, averaged over five rows where all five exist and
// passed through otherwise; rows 0 and 1 give no result until the last row.
// A pixel on the last row of the frame returns up to three pixels (the
// remaining rows of its column, the final one marked by tlast), so input is
// held until all its results are taken; elsewhere the rate is one pixel
// per clock while the output does not stall. Four row memories of 1024
// pixels are read at the current column and written in one slot on the
// same edge as acceptance. Sizes are to be written over the config port
// only while the stream is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module vertical_box_blur_rgb (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_we,
  input  logic [vbb_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [vbb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // pixel input
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [vbb_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // in_red, in_green, in_blue
  // result output
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [vbb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // out_red, out_green,
                                                            // out_blue, out_col, out_row
  output logic                               m_axis_tlast   // run_last
);
  import vbb_pkg::*;

  localparam int PAD_W = OUT_DATA_W - PIX_W - COL_W - ROW_W;

  logic                          accept;
  vbb_item_t                     item;
  logic [SLOTS-1:0][PIX_W-1:0]   rd_pix;
  pix_t                          out_pix;
  logic [COL_W-1:0]              out_col;
  logic [ROW_W-1:0]              out_row;

  assign accept = s_axis_tvalid && s_axis_tready;

  // counters and sizes
  vbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .item      (item)
  );

  // row memories
  vbb_line_store u_line_store (
    .clk     (clk),
    .accept  (accept),
    .col     (item.col),
    .wr_slot (item.row[SLOT_W-1:0]),
    .wr_pix  (s_axis_tdata[PIX_W-1:0]),
    .rd_pix  (rd_pix)
  );

  // average and output
  vbb_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .item      (item),
    .cur_pix   (s_axis_tdata[PIX_W-1:0]),
    .rd_pix    (rd_pix),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_pix   (out_pix),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {{PAD_W{1'b0}}, out_row, out_col, out_pix};

endmodule
